/* hw/rtl/two_key_open_address_hash_table_macros.svh */
// Assertion macros for the two-key hash table
`ifndef TWO_KEY_OPEN_ADDRESS_HASH_TABLE_MACROS_SVH
`define TWO_KEY_OPEN_ADDRESS_HASH_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define HT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define HT_ASSERT_NEXT(lbl, clk, rstn, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error(msg);
`else
`define HT_ASSERT(lbl, clk, rstn, prop, msg)
`define HT_ASSERT_NEXT(lbl, clk, rstn, a, b, msg)
`endif
`endif

/* hw/rtl/tkht_pkg.sv */
// Shared types and codes for the two-key hash table
package tkht_pkg;
  localparam int unsigned KindW = 2;
  localparam int unsigned StatW = 3;
  localparam int unsigned WordW = 32;
  localparam int unsigned SizeW = 11;
  localparam int unsigned ScanW = 10;
  localparam int unsigned SlotW = 10;
  localparam int unsigned OccW  = 11;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_LIVE    = 2'd1,
    MARK_DELETED = 2'd2,
    MARK_UNUSED  = 2'd3
  } mark_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_DELETED  = 3'd2,
    ST_FOUND    = 3'd3,
    ST_ABSENT   = 3'd4,
    ST_FULL     = 3'd5,
    ST_CLEARED  = 3'd6,
    ST_RSVD     = 3'd7
  } status_e;

  localparam logic [0:0] CFG_TABLE_SIZE = 1'b0;
  localparam logic [0:0] CFG_MAX_SCAN   = 1'b1;

  // command passed from front to back
  typedef struct packed {
    kind_e             kind;
    logic [WordW-1:0]  k1;
    logic [WordW-1:0]  k2;
    logic [WordW-1:0]  value;
  } cmd_t;
endpackage

/* hw/rtl/tkht_front.sv */
// Front end: input capture and a two-entry command queue
module tkht_front
  import tkht_pkg::*;
#(
  parameter int unsigned KeyBits = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       kind_i,
  input  logic [WordW-1:0] first_key_i,
  input  logic [WordW-1:0] second_key_i,
  input  logic [WordW-1:0] value_i,
  output logic             cmd_valid_o,
  input  logic             cmd_pop_i,
  output cmd_t             cmd_o
);
  cmd_t       q_mem [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  cmd_t       cin;

  always_comb begin
    cin       = '0;
    cin.kind  = kind_e'(kind_i);
    cin.k1    = first_key_i & WordW'({KeyBits{1'b1}});
    cin.k2    = second_key_i & WordW'({KeyBits{1'b1}});
    cin.value = value_i;
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_mem[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wptr_q] <= cin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

/* hw/rtl/tkht_back.sv */
// Back end: probe sequencer over the slot memories
`include "two_key_open_address_hash_table_macros.svh"
module tkht_back
  import tkht_pkg::*;
#(
  parameter int unsigned Depth = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [SizeW-1:0] cfg_data_i,
  input  logic             cmd_valid_i,
  output logic             cmd_pop_o,
  input  cmd_t             cmd_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [StatW-1:0] status_o,
  output logic [WordW-1:0] found_value_o,
  output logic [SlotW-1:0] slot_index_o,
  output logic [OccW-1:0]  occupancy_o
);
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned RW = AW + 1;
  localparam int unsigned XW = RW + 34;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_RED   = 8'b00000010,
    S_READ  = 8'b00000100,
    S_EVAL  = 8'b00001000,
    S_WR2   = 8'b00010000,
    S_CLR   = 8'b00100000,
    S_DONE  = 8'b01000000,
    S_INIT  = 8'b10000000
  } state_e;

  state_e          st_q, st_d;
  logic [SizeW-1:0] size_q;
  logic [ScanW-1:0] scan_q;
  logic [RW-1:0]   sz_r;

  // memories
  logic [WordW-1:0] mk1 [Depth];
  logic [WordW-1:0] mk2 [Depth];
  logic [WordW-1:0] mdat [Depth];
  logic [1:0]       mmark [Depth];
  logic [WordW-1:0] rk1, rk2, rdat;
  logic [1:0]       rmark;

  cmd_t            c_q;
  logic [34:0]     acc_q;   // value being reduced mod size
  logic [AW-1:0]   idx_q, del_q;
  logic            hdel_q;
  logic [ScanW:0]  n_q;
  logic [OccW-1:0] live_q;
  logic [AW-1:0]   clr_q;
  logic [5:0]      sh_q;
  logic [StatW-1:0] st_o_q;
  logic [WordW-1:0] fv_q;
  logic [AW-1:0]   wh_q;
  logic            ov_q;

  logic            mwe;
  logic [AW-1:0]   wa, ra;
  logic [1:0]      wmark;
  logic            wkeys;
  logic [XW-1:0]   shifted;

  always_comb begin
    if (size_q == '0) sz_r = RW'(1);
    else if (32'(size_q) > Depth) sz_r = RW'(Depth);
    else sz_r = RW'(size_q);
  end

  // restoring reduction: subtract size<<sh for sh from 33 down to 0
  assign shifted = XW'(sz_r) << sh_q;

  always_ff @(posedge clk_i) begin
    if (mwe) begin
      mmark[wa] <= wmark;
      if (wkeys) begin
        mk1[wa]  <= c_q.k1;
        mk2[wa]  <= c_q.k2;
        mdat[wa] <= c_q.value;
      end
    end
    rk1   <= mk1[ra];
    rk2   <= mk2[ra];
    rdat  <= mdat[ra];
    rmark <= mmark[ra];
  end

  logic hit, last;
  assign hit  = (rmark == MARK_LIVE) && (rk1 == c_q.k1) && (rk2 == c_q.k2);
  assign last = (n_q == {1'b0, scan_q});

  assign out_valid_o   = ov_q;
  assign status_o      = st_o_q;
  assign found_value_o = fv_q;
  assign slot_index_o  = SlotW'(wh_q);
  assign occupancy_o   = live_q;
  assign cmd_pop_o     = (st_q == S_IDLE) && cmd_valid_i && !ov_q;

  logic [34:0] nxt_acc;
  assign nxt_acc = 35'({idx_q, 2'b00}) + 35'(idx_q) + 35'(c_q.k2) + {2'b0, c_q.k1, 1'b0};

  always_comb begin
    st_d  = st_q;
    mwe   = 1'b0;
    wa    = idx_q;
    ra    = idx_q;
    wmark = MARK_EMPTY;
    wkeys = 1'b0;
    unique case (st_q)
      S_INIT, S_CLR: begin
        mwe = 1'b1;
        wa  = clr_q;
        if (clr_q == AW'(Depth - 1)) st_d = (st_q == S_CLR) ? S_DONE : S_IDLE;
      end
      S_READ: begin
        ra = acc_q[AW-1:0];
      end
      S_EVAL: begin
        if (c_q.kind == KIND_INSERT) begin
          if (rmark == MARK_EMPTY) begin
            mwe = 1'b1; wkeys = 1'b1; wmark = MARK_LIVE;
            wa  = hdel_q ? del_q : idx_q;
          end else if (hit) begin
            mwe = 1'b1; wkeys = 1'b1; wmark = MARK_LIVE;
            wa  = hdel_q ? del_q : idx_q;
          end else if (last && (hdel_q || rmark == MARK_DELETED)) begin
            mwe = 1'b1; wkeys = 1'b1; wmark = MARK_LIVE;
            wa  = hdel_q ? del_q : idx_q;
          end
        end else if (c_q.kind == KIND_DELETE && hit) begin
          mwe = 1'b1; wmark = MARK_DELETED;
        end
      end
      S_WR2: begin
        mwe = 1'b1; wmark = MARK_DELETED; wa = idx_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_INIT;
      size_q <= SizeW'(1021);
      scan_q <= ScanW'(16);
      live_q <= '0;
      clr_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TABLE_SIZE) size_q <= cfg_data_i;
        else scan_q <= cfg_data_i[ScanW-1:0];
      end
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      unique case (st_q)
        S_INIT, S_CLR: begin
          clr_q <= clr_q + AW'(1);
          if (st_q == S_CLR && clr_q == AW'(Depth - 1)) begin
            live_q <= '0;
            st_o_q <= ST_CLEARED;
          end
          if (clr_q == AW'(Depth - 1)) st_q <= st_d;
        end
        S_IDLE: if (cmd_pop_o) begin
          c_q    <= cmd_i;
          fv_q   <= '0;
          wh_q   <= '0;
          hdel_q <= 1'b0;
          n_q    <= '0;
          del_q  <= '0;
          clr_q  <= '0;
          st_o_q <= ST_ABSENT;
          acc_q  <= {5'b0, cmd_i.k1[31:2]} + {2'b0, cmd_i.k2, 1'b0};
          sh_q   <= 6'd33;
          st_q   <= (cmd_i.kind == KIND_CLEAR) ? S_CLR : S_RED;
        end
        S_RED: begin
          if ({{(XW-35){1'b0}}, acc_q} >= shifted) acc_q <= acc_q - shifted[34:0];
          if (sh_q == 6'd0) st_q <= S_READ;
          else sh_q <= sh_q - 6'd1;
        end
        S_READ: begin
          idx_q <= acc_q[AW-1:0];
          st_q  <= S_EVAL;
        end
        S_EVAL: begin
          st_q <= S_DONE;
          priority if (c_q.kind == KIND_INSERT) begin
            if (rmark == MARK_EMPTY) begin
              st_o_q <= ST_INSERTED; wh_q <= hdel_q ? del_q : idx_q;
              live_q <= live_q + OccW'(1);
            end else if (hit) begin
              st_o_q <= ST_UPDATED; wh_q <= hdel_q ? del_q : idx_q;
              if (hdel_q) st_q <= S_WR2;
            end else if (last) begin
              // a deleted slot on the last probe still takes the entry
              if (hdel_q || rmark == MARK_DELETED) begin
                st_o_q <= ST_INSERTED; wh_q <= hdel_q ? del_q : idx_q;
                live_q <= live_q + OccW'(1);
              end else st_o_q <= ST_FULL;
            end else begin
              if (rmark == MARK_DELETED && !hdel_q) begin
                hdel_q <= 1'b1; del_q <= idx_q;
              end
              st_q <= S_RED;
            end
          end else begin
            if (hit) begin
              wh_q <= idx_q;
              if (c_q.kind == KIND_DELETE) begin
                st_o_q <= ST_DELETED;
                if (live_q != '0) live_q <= live_q - OccW'(1);
              end else begin
                st_o_q <= ST_FOUND; fv_q <= rdat;
              end
            end else if (rmark != MARK_EMPTY && !last) st_q <= S_RED;
          end
          if (st_d == S_EVAL) begin
            acc_q <= nxt_acc;
            sh_q  <= 6'd33;
            n_q   <= n_q + {{ScanW{1'b0}}, 1'b1};
          end
        end
        S_WR2: st_q <= S_DONE;
        S_DONE: if (!ov_q || !out_stall_i) begin
          ov_q <= 1'b1;
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  `HT_ASSERT(a_out_hold, clk_i, rst_ni,
             (ov_q && out_stall_i) |=> ov_q, "result dropped while stalled")
  `HT_ASSERT(a_pop_idle, clk_i, rst_ni,
             cmd_pop_o |-> (st_q == S_IDLE), "command taken while busy")
  `HT_ASSERT_NEXT(a_clr_occ, clk_i, rst_ni, (st_q == S_CLR) && (st_d == S_DONE),
                  live_q == '0, "clear left live entries")
endmodule

/* hw/rtl/two_key_open_address_hash_table.sv */
// Top level of the two-key open addressing hash table
//  channel | valid      | stall       | payload
//  in      | in_valid_i | in_stall_o  | kind_i first_key_i second_key_i value_i
//  out     | out_valid_o| out_stall_i | status_o found_value_o slot_index_o occupancy_o
// Each probe is a 34-step restoring reduction mod table size, one memory read
// and one evaluate; an updated entry that moves back into a deleted slot also
// passes through the S_WR2 state, which marks its old slot deleted.
// Clear sweeps all DEPTH slots, one per cycle; the same sweep runs after reset.
// A stalled result holds the sequencer; a two-entry queue decouples input from
// the probe sequencer.
module two_key_open_address_hash_table
  import tkht_pkg::*;
#(
  parameter int unsigned DEPTH    = 1024,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [SizeW-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       kind_i,
  input  logic [WordW-1:0] first_key_i,
  input  logic [WordW-1:0] second_key_i,
  input  logic [WordW-1:0] value_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [StatW-1:0] status_o,
  output logic [WordW-1:0] found_value_o,
  output logic [SlotW-1:0] slot_index_o,
  output logic [OccW-1:0]  occupancy_o
);
  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  tkht_front #(.KeyBits(KEY_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .first_key_i,
    .second_key_i, .value_i, .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop),
    .cmd_o(cmd)
  );

  tkht_back #(.Depth(DEPTH)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .cmd_i(cmd),
    .out_valid_o, .out_stall_i, .status_o, .found_value_o, .slot_index_o,
    .occupancy_o
  );
endmodule

/* tb/two_key_open_address_hash_table_check.sv */
// Checker for the two-key hash table: mirrors the table and compares every result item
`timescale 1ns / 100ps
module two_key_open_address_hash_table_check
  import tkht_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [SizeW-1:0] cfg_data_i,
  input  logic             in_valid_i,
  input  logic             in_stall_o,
  input  logic [1:0]       kind_i,
  input  logic [WordW-1:0] first_key_i,
  input  logic [WordW-1:0] second_key_i,
  input  logic [WordW-1:0] value_i,
  input  logic             out_valid_o,
  input  logic             out_stall_i,
  input  logic [StatW-1:0] status_o,
  input  logic [WordW-1:0] found_value_o,
  input  logic [SlotW-1:0] slot_index_o,
  input  logic [OccW-1:0]  occupancy_o,
  output int               fail_count,
  output int               pending
);
  localparam int unsigned SLOTS = 1024;

  typedef struct {
    status_e          status;
    logic [WordW-1:0] found;
    logic [SlotW-1:0] slot;
    logic [OccW-1:0]  occ;
  } table_answer_t;

  mark_e            mark_q [SLOTS];
  logic [WordW-1:0] key_a_q[SLOTS];
  logic [WordW-1:0] key_b_q[SLOTS];
  logic [WordW-1:0] data_q [SLOTS];
  int unsigned      live_q;
  logic [SizeW-1:0] size_q;
  logic [ScanW-1:0] scan_q;
  table_answer_t    answers_due[$];

  task automatic report(string what, logic [WordW-1:0] got, logic [WordW-1:0] want);
    $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic void store_slot(longint unsigned i, logic [WordW-1:0] a,
                                     logic [WordW-1:0] b, logic [WordW-1:0] v);
    key_a_q[i] = a;
    key_b_q[i] = b;
    data_q[i]  = v;
    mark_q[i]  = MARK_LIVE;
  endfunction

  // updates the mirrored table and returns the answer the block must give
  function automatic table_answer_t apply_table_op(kind_e kind, logic [WordW-1:0] a,
                                                   logic [WordW-1:0] b, logic [WordW-1:0] v);
    longint unsigned s, idx, del, a64, b64;
    int unsigned     limit, n;
    bit              have_del, done, hit;
    table_answer_t   r;
    a64 = a;
    b64 = b;
    s = (size_q == 0) ? 1 : ((size_q > SLOTS) ? SLOTS : size_q);
    limit = scan_q + 1;
    idx = ((a64 >> 2) + (b64 << 1)) % s;
    r.status = ST_ABSENT;
    r.found = '0;
    r.slot = '0;
    have_del = 0;
    done = 0;
    del = 0;
    if (kind == KIND_CLEAR) begin
      foreach (mark_q[i]) mark_q[i] = MARK_EMPTY;
      live_q = 0;
      r.status = ST_CLEARED;
    end else if (kind == KIND_INSERT) begin
      for (n = 0; n < limit && !done; n++) begin
        hit = mark_q[idx] == MARK_LIVE && key_a_q[idx] == a && key_b_q[idx] == b;
        if (mark_q[idx] == MARK_DELETED) begin
          if (!have_del) begin
            have_del = 1;
            del = idx;
          end
        end else if (mark_q[idx] == MARK_EMPTY) begin
          store_slot(have_del ? del : idx, a, b, v);
          live_q++;
          r.status = ST_INSERTED;
          r.slot = SlotW'(have_del ? del : idx);
          done = 1;
        end else if (hit) begin
          // live entry behind a tombstone moves back into it
          if (have_del) mark_q[idx] = MARK_DELETED;
          store_slot(have_del ? del : idx, a, b, v);
          r.status = ST_UPDATED;
          r.slot = SlotW'(have_del ? del : idx);
          done = 1;
        end
        if (!done) idx = (5 * idx + b64 + 2 * a64) % s;
      end
      if (!done) begin
        if (have_del) begin
          store_slot(del, a, b, v);
          live_q++;
          r.status = ST_INSERTED;
          r.slot = SlotW'(del);
        end else begin
          r.status = ST_FULL;
        end
      end
    end else begin
      for (n = 0; n < limit && !done; n++) begin
        if (mark_q[idx] == MARK_LIVE && key_a_q[idx] == a && key_b_q[idx] == b) begin
          if (kind == KIND_DELETE) begin
            mark_q[idx] = MARK_DELETED;
            if (live_q > 0) live_q--;
            r.status = ST_DELETED;
          end else begin
            r.status = ST_FOUND;
            r.found = data_q[idx];
          end
          r.slot = SlotW'(idx);
          done = 1;
        end else if (mark_q[idx] == MARK_EMPTY) begin
          done = 1;
        end else begin
          idx = (5 * idx + b64 + 2 * a64) % s;
        end
      end
    end
    r.occ = OccW'(live_q);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    table_answer_t want;
    if (!rst_ni) begin
      foreach (mark_q[i]) mark_q[i] = MARK_EMPTY;
      live_q = 0;
      size_q = 11'd1021;
      scan_q = 10'd16;
      answers_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TABLE_SIZE) size_q = cfg_data_i;
        else scan_q = cfg_data_i[ScanW-1:0];
      end
      if (in_valid_i && !in_stall_o)
        answers_due.push_back(apply_table_op(kind_e'(kind_i), first_key_i, second_key_i,
                                             value_i));
      if (out_valid_o && !out_stall_i) begin
        if (answers_due.size() == 0) begin
          report("unexpected item, status", WordW'(status_o), '0);
        end else begin
          want = answers_due.pop_front();
          if (status_o != want.status)
            report("status", WordW'(status_o), WordW'(want.status));
          if (found_value_o != want.found) report("found_value", found_value_o, want.found);
          if (slot_index_o != want.slot)
            report("slot_index", WordW'(slot_index_o), WordW'(want.slot));
          if (occupancy_o != want.occ)
            report("occupancy", WordW'(occupancy_o), WordW'(want.occ));
        end
      end
    end
    pending = answers_due.size();
  end
endmodule

/* tb/two_key_open_address_hash_table_test.sv */
// Top of the hash table testbench: stimulus, idling, config phases and verdict
`timescale 1ns / 100ps
module two_key_open_address_hash_table_test;
  import tkht_pkg::*;

  localparam int CYCLE_LIMIT = 6000000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [0:0]       cfg_idx_i = CFG_TABLE_SIZE;
  logic [SizeW-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [1:0]       kind_i = KIND_SEARCH;
  logic [WordW-1:0] first_key_i = '0;
  logic [WordW-1:0] second_key_i = '0;
  logic [WordW-1:0] value_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [StatW-1:0] status_o;
  logic [WordW-1:0] found_value_o;
  logic [SlotW-1:0] slot_index_o;
  logic [OccW-1:0]  occupancy_o;

  int fail_count;
  int pending;
  int cycles = 0;
  int burst_left = 1;
  bit hold_req = 0;
  logic [WordW-1:0] pool_a[$];
  logic [WordW-1:0] pool_b[$];

  always #5 clk_i = ~clk_i;

  two_key_open_address_hash_table u_top (.*);

  two_key_open_address_hash_table_check u_check (.*);

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("two_key_open_address_hash_table regression: fail");
      $finish;
    end
  end

  // result side: random stall runs, plus a long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_req = 0;
      end else begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  task automatic send_item(kind_e kind, logic [WordW-1:0] a, logic [WordW-1:0] b,
                           logic [WordW-1:0] v);
    in_valid_i <= 1'b1;
    kind_i <= kind;
    first_key_i <= a;
    second_key_i <= b;
    value_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
  endtask

  // stop offering, let the checker see the last item, then wait for every result
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [SizeW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // let any clear sweep finish before touching registers
  task automatic set_table(logic [SizeW-1:0] size, logic [SizeW-1:0] scan);
    drain();
    repeat (1100) @(posedge clk_i);
    write_reg(CFG_TABLE_SIZE, size);
    write_reg(CFG_MAX_SCAN, scan);
  endtask

  task automatic run_random(int count, int keys);
    int   pick, roll;
    kind_e kind;
    logic [WordW-1:0] a, b;
    pool_a.delete();
    pool_b.delete();
    repeat (keys) begin
      pool_a.push_back($urandom());
      pool_b.push_back($urandom());
    end
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) kind = KIND_INSERT;
      else if (roll < 70) kind = KIND_SEARCH;
      else if (roll < 98) kind = KIND_DELETE;
      else kind = KIND_CLEAR;
      pick = $urandom_range(0, keys - 1);
      a = pool_a[pick];
      b = pool_b[pick];
      if ($urandom_range(0, 9) == 0) begin
        a = $urandom();
        b = $urandom();
      end
      send_item(kind, a, b, $urandom());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (1100) @(posedge clk_i);

    // directed: key extremes, every operation, hits and misses
    send_item(KIND_INSERT, '0, '0, '0);
    send_item(KIND_INSERT, '1, '1, '1);
    send_item(KIND_INSERT, '1, '1, 32'h5a5a_a5a5);
    send_item(KIND_SEARCH, '1, '1, '0);
    send_item(KIND_SEARCH, '0, '0, '1);
    send_item(KIND_SEARCH, 32'h1234_5678, 32'h9abc_def0, '0);
    send_item(KIND_DELETE, '0, '0, '0);
    send_item(KIND_DELETE, '0, '0, '0);
    send_item(KIND_SEARCH, '0, '0, '0);
    send_item(KIND_INSERT, '0, '0, 32'hdead_beef);
    send_item(KIND_INSERT, 32'h8000_0000, 32'h0000_0001, 32'h8000_0001);
    send_item(KIND_SEARCH, 32'h8000_0000, 32'h0000_0001, '0);
    send_item(KIND_CLEAR, '1, '1, '1);
    send_item(KIND_SEARCH, '1, '1, '0);
    send_item(KIND_DELETE, '1, '1, '0);

    // tiny table, short scan: full table, tombstone reuse and moves
    set_table(11'd7, 11'd2);
    run_random(240, 12);
    hold_req = 1;
    run_random(20, 12);

    set_table(11'd13, 11'd5);
    run_random(120, 20);
    drain();
    run_random(120, 20);

    // size shrunk while the table holds entries
    set_table(11'd31, 11'd10);
    run_random(160, 40);
    set_table(11'd5, 11'd4);
    run_random(80, 10);

    // zero size counts as one slot; oversize saturates
    set_table(11'd0, 11'd3);
    run_random(100, 4);
    set_table(11'h7ff, 11'd0);
    run_random(150, 60);
    set_table(11'd1021, 11'd16);
    run_random(250, 64);

    // longest scan on a three-slot table; few items, each is slow
    set_table(11'd3, 11'd1023);
    run_random(8, 5);
    set_table(11'd1024, 11'd1);
    run_random(100, 30);

    in_valid_i <= 1'b0;
    drain();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("two_key_open_address_hash_table regression: pass");
    else $display("two_key_open_address_hash_table regression: fail");
    $finish;
  end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/tkht_pkg.sv
hw/rtl/tkht_front.sv
hw/rtl/tkht_back.sv
hw/rtl/two_key_open_address_hash_table.sv
tb/two_key_open_address_hash_table_check.sv
tb/two_key_open_address_hash_table_test.sv
